// File: rtl/epoch_seconds_to_calendar_macros.svh
// Assertion macros shared by the calendar converter RTL.
// No dependencies.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
// implication checked on every clock unless reset is asserted
`define ESC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ESC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/esc_pkg.sv
// Package for the seconds-to-calendar converter: widths, constants, stage records.
// No dependencies.
`default_nettype none
package esc_pkg;
	localparam int unsigned SecW = 32;
	localparam int unsigned DaysW = 16;  // max day count 49710
	localparam int unsigned YearW = 12;
	localparam int unsigned BaseYear = 2000;

	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
	} tod_t;

	typedef struct packed {
		logic [5:0] second_of_minute;
		logic [5:0] minute_of_hour;
		logic [4:0] hour_of_day;
		logic [2:0] weekday;
		logic [11:0] calendar_year;
		logic [3:0] month_number;
		logic [4:0] day_of_month;
	} cal_t;

	function automatic logic is_leap(input logic [YearW-1:0] y);
		// 2100 is the only non-leap century in range
		return (y[1:0] == 2'd0) && (y != 12'd2100);
	endfunction

	// days from epoch to Jan 1 of BaseYear+idx: 365 per year plus one per leap year
	// before it (every fourth index from 0, except index 100)
	function automatic logic [DaysW-1:0] year_start(input logic [7:0] idx);
		logic [DaysW-1:0] d;
		d = DaysW'(idx) * DaysW'(365) + DaysW'((idx + 8'd3) >> 2);
		if (idx > 8'd100)
			d = d - DaysW'(1);
		return d;
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] r;
		case (m)
			4'd0: r = 9'd0;
			4'd1: r = 9'd31;
			4'd2: r = 9'd59;
			4'd3: r = 9'd90;
			4'd4: r = 9'd120;
			4'd5: r = 9'd151;
			4'd6: r = 9'd181;
			4'd7: r = 9'd212;
			4'd8: r = 9'd243;
			4'd9: r = 9'd273;
			4'd10: r = 9'd304;
			4'd11: r = 9'd334;
			default: r = 9'd0;
		endcase
		if (leap && m >= 4'd2)
			r = r + 9'd1;
		return r;
	endfunction
endpackage
`default_nettype wire

// File: rtl/esc_if.sv
// Valid/ready channel interface for the calendar converter.
// No dependencies.
`default_nettype none
interface esc_if #(parameter int unsigned W = 32) (input wire logic clk);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/esc_div.sv
// Time-of-day split: seconds -> sec/min/hour/days over three stages.
// Depends on esc_pkg.
`default_nettype none
module esc_div
	import esc_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic [SecW-1:0] secs,
	output tod_t tod,
	output logic [DaysW-1:0] days
);
	// x/60 as (x>>2)/15: floor(y/15) = (y*ceil(2^34/15))>>34 for 30 bit y
	logic [26:0] q1_s1;
	logic [5:0] sec_s1;
	logic [20:0] q2_s2;
	logic [5:0] sec_s2, min_s2;
	logic [DaysW-1:0] d_s3;
	logic [4:0] h_s3;
	logic [5:0] sec_s3, min_s3;

	logic [60:0] p1;
	logic [26:0] q1;
	logic [53:0] p2;
	logic [20:0] q2;
	logic [39:0] p3;
	logic [DaysW-1:0] q3;

	assign p1 = 61'(secs[SecW-1:2]) * 61'd1145324613;
	assign q1 = p1[60:34];
	// minutes < 2^27: floor(x/60) = (x*ceil(2^33/60))>>33
	assign p2 = 54'(q1_s1) * 54'd143165577;
	assign q2 = p2[53:33];
	assign p3 = 40'(q2_s2) * 40'd699051;
	assign q3 = p3[39:24];

	always_ff @(posedge clk) begin
		if (en) begin
			q1_s1 <= q1;
			sec_s1 <= 6'(secs - 32'(q1) * 32'd60);
			q2_s2 <= q2;
			sec_s2 <= sec_s1;
			min_s2 <= 6'(q1_s1 - 27'(q2) * 27'd60);
			d_s3 <= q3;
			h_s3 <= 5'(q2_s2 - 21'(q3) * 21'd24);
			sec_s3 <= sec_s2;
			min_s3 <= min_s2;
		end
	end
	assign tod = '{sec: sec_s3, min: min_s3, hour: h_s3};
	assign days = d_s3;
endmodule
`default_nettype wire

// File: rtl/esc_date.sv
// Date stages: weekday, year search by estimate and correct, month lookup.
// Depends on esc_pkg.
`default_nettype none
module esc_date
	import esc_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic [DaysW-1:0] days,
	input tod_t tod,
	output cal_t cal
);
	logic [7:0] yi_s4;
	logic [DaysW-1:0] d_s4;
	logic [2:0] wd_s4;
	tod_t tod_s4;
	logic [7:0] yi_s5;
	logic [8:0] doy_s5;
	logic [2:0] wd_s5;
	tod_t tod_s5;
	cal_t cal_s6;

	logic [27:0] pe;
	logic [7:0] est;
	logic [DaysW-1:0] wsum;
	logic [32:0] pw;
	logic [12:0] wq;
	logic [2:0] wmod;
	logic [DaysW-1:0] ys1;
	logic [7:0] yi;
	logic [11:0] yr5;
	logic lp5;
	logic [3:0] mo;
	logic [8:0] ms;

	// est = floor(days/365.25)-ish, never above true index
	assign pe = 28'(days) * 28'd2870;
	assign est = pe[27:20];
	assign wsum = days + DaysW'(6);
	// floor(w/7) = (w*ceil(2^19/7))>>19 for w < 2^16
	assign pw = 33'(wsum) * 33'd74899;
	assign wq = pw[31:19];
	assign wmod = 3'(wsum - DaysW'(wq) * DaysW'(7));

	always_comb begin
		ys1 = year_start(est + 8'd1);
		yi = (days >= ys1) ? est + 8'd1 : est;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yi_s4 <= yi;
			d_s4 <= days;
			wd_s4 <= wmod + 3'd1;
			tod_s4 <= tod;
			yi_s5 <= yi_s4;
			doy_s5 <= 9'(d_s4 - year_start(yi_s4));
			wd_s5 <= wd_s4;
			tod_s5 <= tod_s4;
		end
	end

	assign yr5 = 12'(BaseYear) + 12'(yi_s5);
	assign lp5 = is_leap(yr5);
	always_comb begin
		mo = 4'd0;
		for (int m = 1; m < 12; m++)
			if (doy_s5 >= month_start(4'(m), lp5))
				mo = 4'(m);
		ms = month_start(mo, lp5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cal_s6.second_of_minute <= tod_s5.sec;
			cal_s6.minute_of_hour <= tod_s5.min;
			cal_s6.hour_of_day <= tod_s5.hour;
			cal_s6.weekday <= wd_s5;
			cal_s6.calendar_year <= yr5;
			cal_s6.month_number <= mo + 4'd1;
			cal_s6.day_of_month <= 5'(doy_s5 - ms + 9'd1);
		end
	end
	assign cal = cal_s6;
endmodule
`default_nettype wire

// File: rtl/epoch_seconds_to_calendar.sv
// Seconds since 2000-01-01 to calendar fields; six-stage pipeline, one beat per cycle
// unless stalled. Stages 1-3 hold the reciprocal multiplies of the time-of-day
// split, stage 4 the year estimate and weekday, 5 the day of year, 6 the month table.
// A whole-pipeline stall on output backpressure; depends on esc_pkg, esc_if.
`default_nettype none
`include "epoch_seconds_to_calendar_macros.svh"
module epoch_seconds_to_calendar
	import esc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	esc_if.sink in_ch,
	esc_if.source out_ch
);
	localparam int unsigned Depth = 6;
	logic [Depth-1:0] v_q;
	logic en;
	tod_t tod;
	logic [DaysW-1:0] days;
	cal_t cal;

	assign en = !v_q[Depth-1] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[Depth-2:0], in_ch.valid};
		end
	end

	esc_div u_div (.clk, .en, .secs(in_ch.data[SecW-1:0]), .tod, .days);
	esc_date u_date (.clk, .en, .days, .tod, .cal);

	assign out_ch.valid = v_q[Depth-1];
	assign out_ch.data = cal;

	`ESC_ASSERT_NXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(cal), "stalled result changed")
	`ESC_ASSERT_IMP(a_ranges, clk, arst_n, out_ch.valid, cal.month_number >= 4'd1 && cal.month_number <= 4'd12 && cal.weekday != 3'd0, "field out of range")
	`ESC_ASSERT_NXT(a_flow, clk, arst_n, in_ch.valid && in_ch.ready, v_q[0], "accepted beat lost")
endmodule
`default_nettype wire
